/* src/pwsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsd_pkg: shared types and constants of the pulse width frame decoder
// Frame layout, configuration register codes and the structs that travel
// between the input stage, the capture logic and the result stage.
// ----------------------------------------------------------------------------
package pwsd_pkg;

    // frame layout
    localparam int FRAME_BYTES = 5;
    localparam int BYTE_IDX_W  = 3;
    localparam logic [BYTE_IDX_W-1:0] LAST_BYTE = BYTE_IDX_W'(FRAME_BYTES - 1);
    localparam logic [7:0] FRAME_BITS = 8'd40;

    // time stamps
    localparam int TIME_W = 14;
    localparam logic [TIME_W-1:0] CAPTURE_WINDOW_US = 14'd8000;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENSOR_KIND   = 2'd0,
        REG_ONE_THRESHOLD = 2'd1,
        REG_WINDOW_LOW    = 2'd2,
        REG_WINDOW_HIGH   = 2'd3
    } cfg_index_t;

    typedef enum logic {
        KIND_INTEGER = 1'b0,
        KIND_TENTHS  = 1'b1
    } sensor_kind_t;

    typedef struct packed {
        sensor_kind_t kind;
        logic [7:0]   one_threshold;
        logic [7:0]   window_low;
        logic [7:0]   window_high;
    } cfg_t;

    typedef struct packed {
        logic              line_level;
        logic [TIME_W-1:0] time_us;
        logic              capture_done;
    } item_t;

    // bytes[i] holds frame byte i, byte 0 is sent first
    typedef struct packed {
        logic [FRAME_BYTES-1:0][7:0] bytes;
        logic [7:0]                  bit_total;
    } frame_t;

endpackage

/* src/pwsd_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsd_in_stage: input register
// Holds one accepted item until the capture logic takes it; a new item
// is taken in the same cycle the held one moves on.
// ----------------------------------------------------------------------------
module pwsd_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pwsd_pkg::item_t     in_item,
    input  logic                take,
    output logic                item_valid,
    output pwsd_pkg::item_t     item
);
    import pwsd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // stall while the held item cannot move on
    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* src/pwsd_capture.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsd_capture: edge interval measurement and bit decoding
// Measures the interval between transitions, skips leading intervals that
// fall outside the window, shifts decoded bits into the frame bytes and
// clears everything on the end-of-capture item.
// ----------------------------------------------------------------------------
module pwsd_capture #(
    parameter int MAX_LEAD_SKIPS = 4,
    parameter int MAX_EDGES      = 255
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pwsd_pkg::cfg_t   cfg,
    input  logic             item_valid,
    input  pwsd_pkg::item_t  item,
    output pwsd_pkg::frame_t frame
);
    import pwsd_pkg::*;

    localparam int SKIP_W = (MAX_LEAD_SKIPS > 0) ? $clog2(MAX_LEAD_SKIPS + 1) : 1;
    localparam logic [SKIP_W-1:0] SKIP_LIMIT = SKIP_W'(MAX_LEAD_SKIPS);
    localparam logic [7:0]        EDGE_LIMIT = 8'(MAX_EDGES);

    logic                        prev_level_reg,  prev_level_next;
    logic [TIME_W-1:0]           prev_time_reg,   prev_time_next;
    logic [7:0]                  edge_count_reg,  edge_count_next;
    logic [SKIP_W-1:0]           skips_done_reg,  skips_done_next;
    logic                        skip_over_reg,   skip_over_next;
    logic [FRAME_BYTES-1:0][7:0] bytes_reg,       bytes_next;
    logic [BYTE_IDX_W-1:0]       byte_index_reg,  byte_index_next;
    logic [7:0]                  bit_total_reg,   bit_total_next;

    logic [TIME_W-1:0] interval;
    logic              outside;
    logic              use_bit;
    logic              is_edge;

    // interval since the previous transition, modulo the time stamp range
    assign interval = item.time_us - prev_time_reg;
    assign outside  = (interval < {{(TIME_W-8){1'b0}}, cfg.window_low})
                   || (interval > {{(TIME_W-8){1'b0}}, cfg.window_high});
    assign is_edge  = (item.line_level != prev_level_reg)
                   && (item.time_us <= CAPTURE_WINDOW_US)
                   && (edge_count_reg < EDGE_LIMIT);

    // next capture state
    always_comb
    begin
        prev_level_next = prev_level_reg;
        prev_time_next  = prev_time_reg;
        edge_count_next = edge_count_reg;
        skips_done_next = skips_done_reg;
        skip_over_next  = skip_over_reg;
        bytes_next      = bytes_reg;
        byte_index_next = byte_index_reg;
        bit_total_next  = bit_total_reg;
        use_bit         = 1'b1;

        if (item_valid)
        begin
            if (item.capture_done)
            begin
                prev_level_next = 1'b0;
                prev_time_next  = '0;
                edge_count_next = '0;
                skips_done_next = '0;
                skip_over_next  = 1'b0;
                bytes_next      = '0;
                byte_index_next = '0;
                bit_total_next  = '0;
            end
            else if (is_edge)
            begin
                prev_level_next = item.line_level;
                prev_time_next  = item.time_us;
                edge_count_next = edge_count_reg + 8'd1;
                if (edge_count_reg != 8'd0)
                begin
                    // leading skip phase
                    if (!skip_over_reg)
                    begin
                        if (outside && (skips_done_reg < SKIP_LIMIT))
                        begin
                            skips_done_next = skips_done_reg + SKIP_W'(1);
                            use_bit         = 1'b0;
                        end
                        else
                        begin
                            skip_over_next = 1'b1;
                        end
                    end
                    // a high interval carries one bit
                    if (use_bit && prev_level_reg)
                    begin
                        bytes_next[byte_index_reg] = {bytes_reg[byte_index_reg][6:0],
                            (interval > {{(TIME_W-8){1'b0}}, cfg.one_threshold})};
                        bit_total_next = bit_total_reg + 8'd1;
                        if ((bit_total_next[2:0] == 3'd0) && (byte_index_reg != LAST_BYTE))
                        begin
                            byte_index_next = byte_index_reg + BYTE_IDX_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b0;
            prev_time_reg  <= '0;
            edge_count_reg <= '0;
            skips_done_reg <= '0;
            skip_over_reg  <= 1'b0;
            bytes_reg      <= '0;
            byte_index_reg <= '0;
            bit_total_reg  <= '0;
        end
        else
        begin
            prev_level_reg <= prev_level_next;
            prev_time_reg  <= prev_time_next;
            edge_count_reg <= edge_count_next;
            skips_done_reg <= skips_done_next;
            skip_over_reg  <= skip_over_next;
            bytes_reg      <= bytes_next;
            byte_index_reg <= byte_index_next;
            bit_total_reg  <= bit_total_next;
        end
    end

    assign frame.bytes     = bytes_reg;
    assign frame.bit_total = bit_total_reg;

endmodule

/* src/pwsd_result.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsd_result: frame check and value decoding with output register
// Checks the sum checksum and bit count, decodes humidity and temperature
// in tenths and holds the result until the consumer takes it.
// ----------------------------------------------------------------------------
module pwsd_result (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pwsd_pkg::sensor_kind_t kind,
    input  pwsd_pkg::frame_t      frame,
    input  logic                  load,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  frame_ok,
    output logic                  checksum_match,
    output logic [7:0]            bits_seen,
    output logic [39:0]           raw_frame,
    output logic [15:0]           humidity_tenths,
    output logic signed [15:0]    temperature_tenths
);
    import pwsd_pkg::*;

    logic        valid_reg, valid_next;
    logic        frame_ok_reg;
    logic        match_reg;
    logic [7:0]  bits_reg;
    logic [39:0] raw_reg;
    logic [15:0] hum_reg;
    logic [15:0] temp_reg;

    logic [7:0]  sum;
    logic        match;
    logic [15:0] b0_wide;
    logic [15:0] b2_wide;
    logic [15:0] mag;
    logic [15:0] hum;
    logic [15:0] temp;

    // checksum over the first four bytes
    assign sum   = frame.bytes[0] + frame.bytes[1] + frame.bytes[2] + frame.bytes[3];
    assign match = (frame.bytes[4] == sum);

    assign b0_wide = {8'd0, frame.bytes[0]};
    assign b2_wide = {8'd0, frame.bytes[2]};
    assign mag     = {1'b0, frame.bytes[2][6:0], frame.bytes[3]};

    // value decoding, times ten as two shifts and an add
    always_comb
    begin
        hum  = '0;
        temp = '0;
        if (match)
        begin
            case (kind)
                KIND_INTEGER:
                begin
                    hum  = (b0_wide << 3) + (b0_wide << 1);
                    temp = (b2_wide << 3) + (b2_wide << 1);
                end
                default:
                begin
                    hum  = {frame.bytes[0], frame.bytes[1]};
                    temp = frame.bytes[2][7] ? (16'd0 - mag) : mag;
                end
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_ok_reg <= match && (frame.bit_total == FRAME_BITS);
            match_reg    <= match;
            bits_reg     <= frame.bit_total;
            raw_reg      <= {frame.bytes[0], frame.bytes[1], frame.bytes[2],
                             frame.bytes[3], frame.bytes[4]};
            hum_reg      <= hum;
            temp_reg     <= temp;
        end
    end

    assign out_valid          = valid_reg;
    assign frame_ok           = frame_ok_reg;
    assign checksum_match     = match_reg;
    assign bits_seen          = bits_reg;
    assign raw_frame          = raw_reg;
    assign humidity_tenths    = hum_reg;
    assign temperature_tenths = signed'(temp_reg);

endmodule

/* src/pulse_width_sensor_frame_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_sensor_frame_decoder: single-wire sensor frame decoder
// Decodes the 40-bit humidity and temperature frame from timestamped
// line transitions and reports it on an end-of-capture item.
// ----------------------------------------------------------------------------
// Each transfer on the input carries one line transition (level and time
// stamp) or, with capture_done set, the end of a capture. Transitions give
// no result; the end-of-capture item gives exactly one result with the raw
// frame, the checksum and bit count checks and the decoded values, then
// clears the capture state. The block takes one item per clock cycle while
// in_stall is low: an item waits in the input register and is folded into
// the capture state by a single pass of compare and shift logic, and a
// result is held in the output register, so a result is offered once its
// end-of-capture item leaves the input register, which waits only while an
// earlier result is still waiting. Transitions keep flowing while a result
// waits; only an end-of-capture item waits for a free output register.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must do so only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module pulse_width_sensor_frame_decoder #(
    parameter int MAX_LEAD_SKIPS = 4,
    parameter int MAX_EDGES      = 255
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pwsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pwsd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            line_level,
    input  logic [pwsd_pkg::TIME_W-1:0]     time_us,
    input  logic                            capture_done,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            frame_ok,
    output logic                            checksum_match,
    output logic [7:0]                      bits_seen,
    output logic [39:0]                     raw_frame,
    output logic [15:0]                     humidity_tenths,
    output logic signed [15:0]              temperature_tenths
);
    import pwsd_pkg::*;

    cfg_t   cfg_reg;
    item_t  in_item;
    item_t  item;
    logic   item_valid;
    logic   take;
    frame_t frame;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kind          <= KIND_TENTHS;
            cfg_reg.one_threshold <= 8'd50;
            cfg_reg.window_low    <= 8'd40;
            cfg_reg.window_high   <= 8'd70;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_SENSOR_KIND:   cfg_reg.kind          <= sensor_kind_t'(cfg_data[0]);
                REG_ONE_THRESHOLD: cfg_reg.one_threshold <= cfg_data;
                REG_WINDOW_LOW:    cfg_reg.window_low    <= cfg_data;
                REG_WINDOW_HIGH:   cfg_reg.window_high   <= cfg_data;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    assign in_item.line_level   = line_level;
    assign in_item.time_us      = time_us;
    assign in_item.capture_done = capture_done;

    // a held item moves on unless it needs the busy output register
    assign take = item_valid && (!item.capture_done || !out_valid || !out_stall);

    pwsd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    pwsd_capture #(
        .MAX_LEAD_SKIPS (MAX_LEAD_SKIPS),
        .MAX_EDGES      (MAX_EDGES)
    ) u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (take),
        .item       (item),
        .frame      (frame)
    );

    pwsd_result u_result (
        .clk                (clk),
        .rst_n              (rst_n),
        .kind               (cfg_reg.kind),
        .frame              (frame),
        .load               (take && item.capture_done),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .frame_ok           (frame_ok),
        .checksum_match     (checksum_match),
        .bits_seen          (bits_seen),
        .raw_frame          (raw_frame),
        .humidity_tenths    (humidity_tenths),
        .temperature_tenths (temperature_tenths)
    );

endmodule

/* sim/pwsd_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsd_frame_checker: result checker for the pulse width frame decoder
// Watches the configuration port and both channels. Every accepted input
// transfer is folded into a local copy of the capture state. Every
// end-of-capture transfer queues one expected frame report. Each output
// transfer is compared field by field with the oldest queued report.
// ----------------------------------------------------------------------------
module pwsd_frame_checker #(
    parameter int MAX_LEAD_SKIPS = 4,
    parameter int MAX_EDGES      = 255
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pwsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pwsd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            line_level,
    input  logic [pwsd_pkg::TIME_W-1:0]     time_us,
    input  logic                            capture_done,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic                            frame_ok,
    input  logic                            checksum_match,
    input  logic [7:0]                      bits_seen,
    input  logic [39:0]                     raw_frame,
    input  logic [15:0]                     humidity_tenths,
    input  logic signed [15:0]              temperature_tenths,
    output int                              fail_count,
    output int                              pending
);
    import pwsd_pkg::*;

    typedef struct packed {
        logic        frame_ok;
        logic        checksum_match;
        logic [7:0]  bits_seen;
        logic [39:0] raw_frame;
        logic [15:0] humidity_tenths;
        logic [15:0] temperature_tenths;
    } frame_report_t;

    // local copy of the registers
    sensor_kind_t kind;
    logic [7:0]   one_threshold;
    logic [7:0]   window_low;
    logic [7:0]   window_high;

    // local copy of the capture state
    logic              prev_level;
    logic [TIME_W-1:0] prev_time;
    int                edge_count;
    int                skips_done;
    logic              skip_over;
    logic [7:0]        frame_bytes [FRAME_BYTES];
    logic [BYTE_IDX_W-1:0] byte_index;
    logic [7:0]        bit_total;

    frame_report_t reports_due [$];

    task automatic clear_capture_state();
        prev_level = 1'b0;
        prev_time  = '0;
        edge_count = 0;
        skips_done = 0;
        skip_over  = 1'b0;
        foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
        byte_index = '0;
        bit_total  = 8'h00;
    endtask

    // one measured interval: lead skipping, then a bit per high interval
    task automatic fold_interval(input logic [TIME_W-1:0] len, input logic level);
        if (!skip_over) begin
            if ((len < window_low || len > window_high) && skips_done < MAX_LEAD_SKIPS) begin
                skips_done++;
                return;
            end
            skip_over = 1'b1;
        end
        if (level) begin
            frame_bytes[byte_index] = {frame_bytes[byte_index][6:0], len > one_threshold};
            bit_total++;
            if (bit_total[2:0] == 3'd0)
                byte_index++;
            if (byte_index > LAST_BYTE)
                byte_index = LAST_BYTE;
        end
    endtask

    // report for the frame gathered so far
    function automatic frame_report_t close_capture();
        frame_report_t rep;
        logic [7:0]    sum8;
        logic [14:0]   mag;
        sum8 = frame_bytes[0] + frame_bytes[1] + frame_bytes[2] + frame_bytes[3];
        rep.checksum_match     = (frame_bytes[4] == sum8);
        rep.bits_seen          = bit_total;
        rep.frame_ok           = rep.checksum_match && (bit_total == FRAME_BITS);
        rep.raw_frame          = {frame_bytes[0], frame_bytes[1], frame_bytes[2],
                                  frame_bytes[3], frame_bytes[4]};
        rep.humidity_tenths    = 16'h0000;
        rep.temperature_tenths = 16'h0000;
        if (rep.checksum_match) begin
            if (kind == KIND_INTEGER) begin
                rep.humidity_tenths    = 16'(frame_bytes[0]) * 16'd10;
                rep.temperature_tenths = 16'(frame_bytes[2]) * 16'd10;
            end else begin
                mag = {frame_bytes[2][6:0], frame_bytes[3]};
                rep.humidity_tenths    = {frame_bytes[0], frame_bytes[1]};
                rep.temperature_tenths = frame_bytes[2][7] ? 16'd0 - {1'b0, mag}
                                                           : {1'b0, mag};
            end
        end
        return rep;
    endfunction

    // one accepted input transfer
    task automatic track_item(input logic level, input logic [TIME_W-1:0] t,
                              input logic done);
        if (done) begin
            reports_due.push_back(close_capture());
            clear_capture_state();
        end else if (level != prev_level && t <= CAPTURE_WINDOW_US
                     && edge_count < MAX_EDGES) begin
            if (edge_count > 0)
                fold_interval(t - prev_time, prev_level);
            prev_level = level;
            prev_time  = t;
            edge_count++;
        end
    endtask

    // one accepted output transfer against the oldest queued report
    task automatic check_report();
        frame_report_t want;
        if (reports_due.size() == 0) begin
            $error("result transfer with no frame report due");
            fail_count++;
        end else begin
            want = reports_due.pop_front();
            if (frame_ok !== want.frame_ok) begin
                $error("frame_ok: expected %0d, actual %0d", want.frame_ok, frame_ok);
                fail_count++;
            end
            if (checksum_match !== want.checksum_match) begin
                $error("checksum_match: expected %0d, actual %0d",
                       want.checksum_match, checksum_match);
                fail_count++;
            end
            if (bits_seen !== want.bits_seen) begin
                $error("bits_seen: expected %0d, actual %0d", want.bits_seen, bits_seen);
                fail_count++;
            end
            if (raw_frame !== want.raw_frame) begin
                $error("raw_frame: expected %h, actual %h", want.raw_frame, raw_frame);
                fail_count++;
            end
            if (humidity_tenths !== want.humidity_tenths) begin
                $error("humidity_tenths: expected %0d, actual %0d",
                       want.humidity_tenths, humidity_tenths);
                fail_count++;
            end
            if (temperature_tenths !== want.temperature_tenths) begin
                $error("temperature_tenths: expected %0d, actual %0d",
                       $signed(want.temperature_tenths), temperature_tenths);
                fail_count++;
            end
        end
    endtask

    // sample both channels and the register port at each edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            kind          = KIND_TENTHS;
            one_threshold = 8'd50;
            window_low    = 8'd40;
            window_high   = 8'd70;
            clear_capture_state();
            reports_due.delete();
            fail_count = 0;
            pending    = 0;
        end else begin
            if (out_valid && !out_stall)
                check_report();
            if (cfg_we) begin
                case (cfg_index)
                    REG_SENSOR_KIND:   kind          = sensor_kind_t'(cfg_data[0]);
                    REG_ONE_THRESHOLD: one_threshold = cfg_data;
                    REG_WINDOW_LOW:    window_low    = cfg_data;
                    REG_WINDOW_HIGH:   window_high   = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                track_item(line_level, time_us, capture_done);
            pending = reports_due.size();
        end
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the pulse width frame decoder
// Plays captures of timed line transitions, each closed by an end-of-capture
// item: a directed set of special frames first, then random well-formed,
// broken and noisy captures under several register settings. Both channels
// idle at random; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
    import pwsd_pkg::*;

    localparam int LONG_HOLD      = 200;
    localparam int ITEM_TARGET    = 1500;
    localparam int CAPTURE_TARGET = 24;
    localparam int SETTLE_CYCLES  = 8;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  line_level;
    logic [TIME_W-1:0]     time_us;
    logic                  capture_done;
    logic                  out_valid;
    logic                  out_stall;
    logic                  frame_ok;
    logic                  checksum_match;
    logic [7:0]            bits_seen;
    logic [39:0]           raw_frame;
    logic [15:0]           humidity_tenths;
    logic signed [15:0]    temperature_tenths;
    int                    fail_count;
    int                    pending;

    // pacing controls for the sender and the receiver
    bit tx_steady;
    bit rx_steady;
    bit hold_off_req;

    // register values last written, used to shape pulse lengths
    sensor_kind_t cur_kind;
    logic [7:0]   cur_thr;
    logic [7:0]   cur_wlo;
    logic [7:0]   cur_whi;

    // capture under construction
    item_t             capture_q [$];
    logic              gen_level;
    logic [TIME_W-1:0] gen_time;
    int unsigned       useful_items;
    int unsigned       captures;

    pulse_width_sensor_frame_decoder dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .line_level         (line_level),
        .time_us            (time_us),
        .capture_done       (capture_done),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .frame_ok           (frame_ok),
        .checksum_match     (checksum_match),
        .bits_seen          (bits_seen),
        .raw_frame          (raw_frame),
        .humidity_tenths    (humidity_tenths),
        .temperature_tenths (temperature_tenths)
    );

    pwsd_frame_checker frame_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .line_level         (line_level),
        .time_us            (time_us),
        .capture_done       (capture_done),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .frame_ok           (frame_ok),
        .checksum_match     (checksum_match),
        .bits_seen          (bits_seen),
        .raw_frame          (raw_frame),
        .humidity_tenths    (humidity_tenths),
        .temperature_tenths (temperature_tenths),
        .fail_count         (fail_count),
        .pending            (pending)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // idle length: mostly none, sometimes short, rarely long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // receiver: random stall bursts, steady stretches, one long hold-off on request
    initial
    begin
        int unsigned n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
                hold_off_req = 1'b0;
            end else begin
                n = rx_steady ? 0 : idle_len();
                if (n != 0) begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                out_stall <= 1'b0;
            end
        end
    end

    function automatic item_t make_item(input logic level, input logic [TIME_W-1:0] t,
                                        input logic done);
        item_t it;
        it.line_level   = level;
        it.time_us      = t;
        it.capture_done = done;
        return it;
    endfunction

    // five bytes with a valid sum in the last one
    function automatic logic [39:0] with_sum(input logic [7:0] b0, b1, b2, b3);
        logic [7:0] s;
        s = b0 + b1 + b2 + b3;
        return {b0, b1, b2, b3, s};
    endfunction

    function automatic logic [39:0] random_frame();
        return with_sum(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // pulse lengths relative to the current window and threshold
    function automatic logic [TIME_W-1:0] lead_len();
        if (cur_wlo != 0 && $urandom_range(0, 1) == 0)
            return TIME_W'($urandom_range(0, cur_wlo - 1));
        return TIME_W'(cur_whi + $urandom_range(1, 120));
    endfunction

    function automatic logic [TIME_W-1:0] low_len();
        if (cur_wlo <= cur_whi)
            return TIME_W'($urandom_range(cur_wlo, cur_whi));
        return TIME_W'($urandom_range(1, 100));
    endfunction

    function automatic logic [TIME_W-1:0] bit_len(input logic b);
        if (b)
            return TIME_W'(cur_thr + $urandom_range(1, 40));
        return TIME_W'($urandom_range(0, cur_thr));
    endfunction

    // one input transfer, with an optional idle gap in front
    task automatic send_item(input item_t it);
        int unsigned gap;
        gap = tx_steady ? 0 : idle_len();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        line_level   <= it.line_level;
        time_us      <= it.time_us;
        capture_done <= it.capture_done;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // stop sending and wait for every frame report to come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // all four registers in consecutive cycles; only while idle
    task automatic write_config(input sensor_kind_t kind, input logic [7:0] thr,
                                input logic [7:0] lo, input logic [7:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SENSOR_KIND;
        cfg_data  <= CFG_DATA_W'(kind);
        @(posedge clk);
        cfg_index <= REG_ONE_THRESHOLD;
        cfg_data  <= thr;
        @(posedge clk);
        cfg_index <= REG_WINDOW_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= REG_WINDOW_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_kind = kind;
        cur_thr  = thr;
        cur_wlo  = lo;
        cur_whi  = hi;
    endtask

    // ignored or disruptive item slipped into a capture
    task automatic add_noise();
        case ($urandom_range(0, 2))
            0: capture_q.push_back(make_item(gen_level, TIME_W'($urandom), 1'b0));
            1: capture_q.push_back(make_item(~gen_level,
                                             TIME_W'($urandom_range(8001, 16383)), 1'b0));
            default:
            begin
                gen_time  = TIME_W'($urandom);
                gen_level = ~gen_level;
                capture_q.push_back(make_item(gen_level, gen_time, 1'b0));
            end
        endcase
    endtask

    // first rising edge of a capture
    task automatic open_capture();
        capture_q.delete();
        gen_level = 1'b1;
        gen_time  = TIME_W'($urandom_range(0, 60));
        capture_q.push_back(make_item(gen_level, gen_time, 1'b0));
        useful_items++;
    endtask

    // hold the current level for len, then toggle
    task automatic step(input logic [TIME_W-1:0] len, input int unsigned noise_pct);
        if ($urandom_range(0, 99) < noise_pct)
            add_noise();
        gen_time  = gen_time + len;
        gen_level = ~gen_level;
        capture_q.push_back(make_item(gen_level, gen_time, 1'b0));
        useful_items++;
    endtask

    // end-of-capture item, then play the whole capture
    task automatic close_and_send();
        capture_q.push_back(make_item(1'($urandom), TIME_W'($urandom), 1'b1));
        useful_items++;
        captures++;
        foreach (capture_q[i]) send_item(capture_q[i]);
        capture_q.delete();
    endtask

    // lead intervals outside the window, then nbits data bits msb first
    task automatic play_capture(input logic [39:0] payload, input int unsigned nbits,
                                input int unsigned n_lead, input int unsigned noise_pct);
        int unsigned k;
        logic        b;
        open_capture();
        for (k = 0; k < n_lead; k++)
            step(lead_len(), noise_pct);
        k = 0;
        while (k < nbits)
        begin
            if (gen_level) begin
                b = (k < 40) ? payload[39 - k] : 1'($urandom);
                step(bit_len(b), noise_pct);
                k++;
            end else begin
                step(low_len(), noise_pct);
            end
        end
        close_and_send();
    endtask

    task automatic random_config();
        logic [7:0] lo;
        if ($urandom_range(0, 4) == 0) begin
            write_config(sensor_kind_t'($urandom_range(0, 1)), 8'($urandom),
                         8'($urandom), 8'($urandom));
        end else begin
            lo = 8'($urandom_range(20, 60));
            write_config(sensor_kind_t'($urandom_range(0, 1)), 8'($urandom_range(20, 120)),
                         lo, lo + 8'($urandom_range(0, 60)));
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int unsigned phase_left;
        int unsigned pick;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_SENSOR_KIND;
        cfg_data     = '0;
        in_valid     = 1'b0;
        line_level   = 1'b0;
        time_us      = '0;
        capture_done = 1'b0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        hold_off_req = 1'b0;
        cur_kind     = KIND_TENTHS;
        cur_thr      = 8'd50;
        cur_wlo      = 8'd40;
        cur_whi      = 8'd70;
        useful_items = 0;
        captures     = 0;
        phase_left   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: positive, negative and negative zero temperature
        play_capture(with_sum(8'h02, 8'h58, 8'h00, 8'hFA), 40, 3, 0);
        play_capture(with_sum(8'h01, 8'h90, 8'h80, 8'h65), 40, 1, 0);
        play_capture(with_sum(8'h00, 8'h00, 8'h80, 8'h00), 40, 3, 0);
        play_capture(with_sum(8'hFF, 8'hFF, 8'hFF, 8'hFF), 40, 3, 0);
        // checksum failure, byte overflow, short frame
        play_capture(with_sum(8'h12, 8'h34, 8'h56, 8'h78) ^ 40'h01, 40, 3, 0);
        play_capture(random_frame(), 41, 3, 0);
        play_capture(random_frame(), 39, 1, 0);
        // end of capture with no edges at all
        capture_q.delete();
        close_and_send();
        // more edges than the block counts
        open_capture();
        repeat (270) step(TIME_W'(1), 0);
        close_and_send();
        // no level change, edge at time zero, late edges, time going backwards
        capture_q.delete();
        capture_q.push_back(make_item(1'b0, TIME_W'(5), 1'b0));
        capture_q.push_back(make_item(1'b1, TIME_W'(0), 1'b0));
        capture_q.push_back(make_item(1'b0, TIME_W'(9000), 1'b0));
        capture_q.push_back(make_item(1'b0, CAPTURE_WINDOW_US, 1'b0));
        capture_q.push_back(make_item(1'b1, TIME_W'(16383), 1'b0));
        capture_q.push_back(make_item(1'b1, TIME_W'(7990), 1'b0));
        capture_q.push_back(make_item(1'b0, TIME_W'(7000), 1'b0));
        capture_q.push_back(make_item(1'b1, TIME_W'(7060), 1'b0));
        close_and_send();

        // receiver holds off while the sender keeps offering frame ends
        tx_steady    = 1'b1;
        rx_steady    = 1'b1;
        hold_off_req = 1'b1;
        repeat (6) play_capture(random_frame(), 2, 0, 0);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        drain();

        // register extremes
        write_config(KIND_INTEGER, 8'd0, 8'd0, 8'd0);
        play_capture(with_sum(8'd55, 8'd0, 8'd25, 8'd0), 40, 1, 0);
        play_capture(random_frame(), 40, 3, 0);
        drain();
        write_config(KIND_TENTHS, 8'd255, 8'd255, 8'd255);
        play_capture(random_frame(), 40, 1, 0);
        drain();
        write_config(KIND_INTEGER, 8'd255, 8'd0, 8'd255);
        play_capture(random_frame(), 40, 3, 0);

        // random captures, new settings every few frames
        while (useful_items < ITEM_TARGET || captures < CAPTURE_TARGET)
        begin
            if (phase_left == 0) begin
                drain();
                random_config();
                phase_left = 8;
            end
            phase_left--;
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 65)
                play_capture(random_frame(), 40, $urandom_range(0, 1) ? 3 : 1, 0);
            else if (pick < 75)
                play_capture(random_frame() ^ (40'd1 << $urandom_range(0, 7)), 40, 1, 0);
            else if (pick < 88)
                play_capture(40'({$urandom, $urandom}), $urandom_range(0, 48),
                             $urandom_range(0, 6), 0);
            else
                play_capture(random_frame(), 40, $urandom_range(0, 6), 12);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        drain();

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
